// File: hdl/rlde_pkg.sv
package rlde_pkg;

	// Width of the encoded delay format and of the threshold register.
	localparam int VAL_BITS       = 36;
	// Default width of the pending delay total.
	localparam int DELAY_BITS_DEF = 36;

	// Command queue between the front end and the serializer.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = 1;
	localparam int QCNT_BITS   = 2;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_DELAY  = 2'd0,
		OP_WRITE  = 2'd1,
		OP_END    = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	// Byte pairs of one command, in the order they are sent.
	typedef enum logic [2:0] {
		PR_FULL = 3'd0,
		PR_TOP  = 3'd1,
		PR_MID  = 3'd2,
		PR_LOW  = 3'd3,
		PR_REG  = 3'd4,
		PR_END  = 3'd5
	} pair_t;

	localparam int NUM_PAIRS = 6;
	typedef logic [NUM_PAIRS-1:0] pair_mask_t;

	// Fixed byte values of the encoding.
	localparam logic [11:0] CHUNK_ALL     = 12'hFFF;
	localparam logic [7:0]  BYTE_FF       = 8'hFF;
	localparam logic [7:0]  BYTE_FULL_TAG = 8'h3F;
	localparam logic [3:0]  TAG_TOP       = 4'h3;
	localparam logic [3:0]  TAG_MID       = 4'h2;
	localparam logic [3:0]  TAG_LOW       = 4'h1;
	localparam logic [3:0]  NIB_ZERO      = 4'h0;

	// One queued command: which pairs to send and the data they draw on.
	typedef struct packed {
		pair_mask_t          pairs;
		logic [VAL_BITS-1:0] delay;
		logic [3:0]          reg_num;
		logic [7:0]          reg_data;
	} cmd_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// File: hdl/rlde_ifs.sv
// Log item channel.
interface rlde_item_if;
	import rlde_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [VAL_BITS-1:0] delay_amount;
	logic [7:0]          register_number;
	logic [7:0]          register_data;

	modport source (
		output valid, operation, delay_amount, register_number, register_data,
		input  ready
	);
	modport sink (
		input  valid, operation, delay_amount, register_number, register_data,
		output ready
	);
endinterface

// Encoded byte channel.
interface rlde_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (
		output valid, out_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last_byte,
		output ready
	);
endinterface

// File: hdl/rlde_fifo.sv
module rlde_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rlde_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output rlde_pkg::cmd_t    pop_cmd,
	output rlde_pkg::q_stat_t stat
);
	import rlde_pkg::*;

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign stat.full     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.nonempty = (count_q != '0);
	assign pop_cmd       = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_BITS'(rd_ptr_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10: count_q <= QCNT_BITS'(count_q + 1'b1);
				2'b01: count_q <= QCNT_BITS'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// The front end never writes a full queue, the serializer never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_BITS'(QUEUE_DEPTH)))
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("command queue underflow");

endmodule

// File: hdl/rlde_front.sv
module rlde_front #(
	parameter int DELAY_BITS = rlde_pkg::DELAY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rlde_item_if.sink                     item,
	input  logic                          cfg_wr_en,
	input  logic [rlde_pkg::VAL_BITS-1:0] cfg_wr_data,
	input  rlde_pkg::q_stat_t             q_stat,
	output logic                          push,
	output rlde_pkg::cmd_t                push_cmd
);
	import rlde_pkg::*;

	logic [VAL_BITS-1:0]   threshold_q;
	logic [DELAY_BITS-1:0] pending_q;
	logic                  ended_q;

	logic                  accept;
	op_t                   op;
	logic [VAL_BITS-1:0]   pend_ext;
	logic [VAL_BITS:0]     sum;
	logic                  sat;
	logic                  flush;
	logic                  full_chunk;

	assign item.ready = !q_stat.full;
	assign accept     = item.valid && item.ready && !ended_q;
	assign op         = op_t'(item.operation);

	// Saturating delay sum and flush decision.
	assign pend_ext   = VAL_BITS'(pending_q);
	assign sum        = (VAL_BITS+1)'(pending_q) + (VAL_BITS+1)'(item.delay_amount);
	assign sat        = |sum[VAL_BITS:DELAY_BITS];
	assign flush      = (pending_q != '0) && (pend_ext >= threshold_q);
	assign full_chunk = (pend_ext[35:24] == CHUNK_ALL);

	// Classify the word into a command for the serializer.
	always_comb begin
		push              = 1'b0;
		push_cmd.pairs    = '0;
		push_cmd.delay    = pend_ext;
		push_cmd.reg_num  = item.register_number[3:0];
		push_cmd.reg_data = item.register_data;
		if (accept) begin
			unique case (op)
				OP_WRITE: begin
					push                   = 1'b1;
					push_cmd.pairs[PR_REG] = 1'b1;
					if (flush) begin
						push_cmd.pairs[PR_FULL] = full_chunk;
						push_cmd.pairs[PR_TOP]  = (pend_ext[35:24] != '0) && !full_chunk;
						push_cmd.pairs[PR_MID]  = (pend_ext[23:12] != '0);
						push_cmd.pairs[PR_LOW]  = (pend_ext[11:0] != '0);
					end
				end
				OP_END: begin
					push                   = 1'b1;
					push_cmd.pairs[PR_END] = 1'b1;
				end
				OP_DELAY, OP_UNUSED: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// Pending delay and end-of-stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			ended_q   <= 1'b0;
		end else if (accept) begin
			unique case (op)
				OP_DELAY: pending_q <= sat ? '1 : sum[DELAY_BITS-1:0];
				OP_WRITE: begin
					if (flush) begin
						pending_q <= '0;
					end
				end
				OP_END:    ended_q <= 1'b1;
				OP_UNUSED: ended_q <= ended_q;
			endcase
		end
	end

	// Once the stream has ended, the pending total is frozen.
	a_frozen_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> $stable(pending_q) && ended_q)
		else $error("state changed after end of stream");
	a_no_push_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !push)
		else $error("command issued after end of stream");

endmodule

// File: hdl/rlde_back.sv
module rlde_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rlde_pkg::cmd_t    pop_cmd,
	input  rlde_pkg::q_stat_t q_stat,
	output logic              pop,
	rlde_byte_if.source       stream
);
	import rlde_pkg::*;

	pair_mask_t          mask_q;
	logic [VAL_BITS-1:0] delay_q;
	logic [3:0]          reg_num_q;
	logic [7:0]          reg_data_q;
	logic                half_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;

	logic                busy;
	pair_t               sel;
	pair_mask_t          rest_mask;
	logic [7:0]          byte_hi;
	logic [7:0]          byte_lo;
	logic [7:0]          cur_byte;
	logic                cur_last;
	logic                advance;

	assign busy = |mask_q;

	// Pick the first pair still to send.
	always_comb begin
		priority if (mask_q[PR_FULL]) sel = PR_FULL;
		else if (mask_q[PR_TOP])      sel = PR_TOP;
		else if (mask_q[PR_MID])      sel = PR_MID;
		else if (mask_q[PR_LOW])      sel = PR_LOW;
		else if (mask_q[PR_REG])      sel = PR_REG;
		else                          sel = PR_END;
	end

	always_comb begin
		rest_mask      = mask_q;
		rest_mask[sel] = 1'b0;
	end

	// Byte values of the selected pair.
	always_comb begin
		unique case (sel)
			PR_FULL: begin
				byte_hi = BYTE_FULL_TAG;
				byte_lo = BYTE_FF;
			end
			PR_TOP: begin
				byte_hi = {TAG_TOP, delay_q[35:32]};
				byte_lo = delay_q[31:24];
			end
			PR_MID: begin
				byte_hi = {TAG_MID, delay_q[23:20]};
				byte_lo = delay_q[19:12];
			end
			PR_LOW: begin
				byte_hi = {TAG_LOW, delay_q[11:8]};
				byte_lo = delay_q[7:0];
			end
			PR_REG: begin
				byte_hi = {NIB_ZERO, reg_num_q};
				byte_lo = reg_data_q;
			end
			PR_END: begin
				byte_hi = BYTE_FF;
				byte_lo = BYTE_FF;
			end
			default: begin
				byte_hi = BYTE_FF;
				byte_lo = BYTE_FF;
			end
		endcase
	end

	assign cur_byte = half_q ? byte_lo : byte_hi;
	assign cur_last = half_q && (rest_mask == '0);
	assign advance  = busy && (!out_valid_q || stream.ready);
	assign pop      = q_stat.nonempty && (!busy || (advance && cur_last));

	// Serializer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= pop_cmd.pairs;
				half_q <= 1'b0;
			end else if (advance) begin
				if (half_q) begin
					mask_q <= rest_mask;
				end
				half_q <= ~half_q;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command data and output word.
	always_ff @(posedge clk) begin
		if (pop) begin
			delay_q    <= pop_cmd.delay;
			reg_num_q  <= pop_cmd.reg_num;
			reg_data_q <= pop_cmd.reg_data;
		end
		if (advance) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign stream.valid     = out_valid_q;
	assign stream.out_byte  = out_byte_q;
	assign stream.last_byte = out_last_q;

	// A second byte is only pending inside a command.
	a_half_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !half_q)
		else $error("serializer mid-pair with no command");
	// A word that is not the last of its command leaves more bytes to send.
	a_more_after_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> busy)
		else $error("command ended without a last word");

endmodule

// File: hdl/register_log_delay_encoder.sv
// Register-log delay encoder. Each log item is taken on the item channel and each encoded
// byte leaves on the stream channel as one word, last_byte marking the final word of its
// item. A delay item is taken by the front end and yields no words; a register write
// yields 2 to 8 words (flushed delay pairs, then register and data) and an end item yields
// 2 words, after which every item is taken and dropped. The front end accepts one item per
// cycle while its two-entry command queue has room; the serializer behind the queue sends
// one word per cycle while the receiver is ready. The user writes the threshold through
// cfg_wr_en/cfg_wr_data only while idle; the block itself does not enforce this.
module register_log_delay_encoder #(
	parameter int DELAY_BITS = rlde_pkg::DELAY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rlde_item_if.sink                     item,
	rlde_byte_if.source                   stream,
	input  logic                          cfg_wr_en,
	input  logic [rlde_pkg::VAL_BITS-1:0] cfg_wr_data
);
	import rlde_pkg::*;

	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    pop_cmd;
	q_stat_t q_stat;

	// Front end: delay accumulation and command classification.
	rlde_front #(
		.DELAY_BITS (DELAY_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// Command queue.
	rlde_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	// Byte serializer.
	rlde_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_cmd (pop_cmd),
		.q_stat  (q_stat),
		.pop     (pop),
		.stream  (stream)
	);

endmodule

// File: tb/sv/rlde_tb_pkg.sv
`timescale 1ns / 1ps

package rlde_tb_pkg;
	import rlde_pkg::*;

	// Delay ticks covered by one full-chunk pair.
	localparam logic [VAL_BITS-1:0] FULL_CHUNK_TICKS = {CHUNK_ALL, 24'd0};

	// One encoded word as it should leave the stream channel.
	typedef struct {
		logic [7:0] value;
		logic       last;
	} encoded_word_t;

	class byte_stream_scoreboard;
		logic [VAL_BITS-1:0] threshold;
		logic [VAL_BITS-1:0] pending;
		bit                  ended;
		encoded_word_t       expected_q[$];
		int                  errors;

		function new();
			threshold = '0;
			pending   = '0;
			ended     = 1'b0;
			errors    = 0;
		endfunction

		function void set_threshold(logic [VAL_BITS-1:0] value);
			threshold = value;
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction

		function void push_byte(logic [7:0] value);
			encoded_word_t w;
			w.value = value;
			w.last  = 1'b0;
			expected_q.push_back(w);
		endfunction

		// Works out the words that one accepted log item should produce.
		function void note_item(op_t op, logic [VAL_BITS-1:0] amount, logic [7:0] num,
				logic [7:0] data);
			int                  first;
			logic [VAL_BITS:0]   sum;
			logic [VAL_BITS-1:0] rest;
			first = expected_q.size();
			if (ended) begin
				return;
			end
			case (op)
				OP_DELAY: begin
					// The total saturates at all ones.
					sum     = {1'b0, pending} + {1'b0, amount};
					pending = sum[VAL_BITS] ? '1 : sum[VAL_BITS-1:0];
				end
				OP_WRITE: begin
					// A nonzero total at or above the threshold is flushed first.
					if (pending != '0 && pending >= threshold) begin
						rest = pending;
						while (rest >= FULL_CHUNK_TICKS) begin
							push_byte(BYTE_FULL_TAG);
							push_byte(BYTE_FF);
							rest = rest - FULL_CHUNK_TICKS;
						end
						if (rest[35:24] != '0) begin
							push_byte({TAG_TOP, rest[35:32]});
							push_byte(rest[31:24]);
						end
						if (rest[23:12] != '0) begin
							push_byte({TAG_MID, rest[23:20]});
							push_byte(rest[19:12]);
						end
						if (rest[11:0] != '0) begin
							push_byte({TAG_LOW, rest[11:8]});
							push_byte(rest[7:0]);
						end
						pending = '0;
					end
					push_byte({NIB_ZERO, num[3:0]});
					push_byte(data);
				end
				OP_END: begin
					push_byte(BYTE_FF);
					push_byte(BYTE_FF);
					ended = 1'b1;
				end
				default: begin
				end
			endcase
			if (expected_q.size() > first) begin
				expected_q[expected_q.size()-1].last = 1'b1;
			end
		endfunction

		function void flag(string what, logic [7:0] want, logic [7:0] got);
			$display("%0t: %s expected 0x%02h, got 0x%02h", $time, what, want, got);
			errors++;
		endfunction

		// Compares one accepted word with the oldest expectation.
		function void check_word(logic [7:0] value, logic last);
			encoded_word_t w;
			if (expected_q.size() == 0) begin
				$display("%0t: word 0x%02h (last_byte %0b) arrived with none expected",
					$time, value, last);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (value !== w.value) begin
				flag("out_byte", w.value, value);
			end
			if (last !== w.last) begin
				flag("last_byte", {7'd0, w.last}, {7'd0, last});
			end
		endfunction
	endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rlde_pkg::*;
	import rlde_tb_pkg::*;

	localparam int HOLD_CYCLES    = 150;
	localparam int SETTLE_CYCLES  = 10;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 48;
	localparam int NUM_PHASES     = 7;
	localparam logic [VAL_BITS-1:0] DELAY_MAX = '1;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [VAL_BITS-1:0] cfg_wr_data;

	rlde_item_if item_ch ();
	rlde_byte_if byte_ch ();

	byte_stream_scoreboard sb;
	bit hold_req;
	int burst_left;
	int idle_cycles;

	register_log_delay_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.stream     (byte_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watch both channels at the rising edge and keep the watchdog.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (item_ch.valid && item_ch.ready) begin
				sb.note_item(op_t'(item_ch.operation), item_ch.delay_amount,
					item_ch.register_number, item_ch.register_data);
			end
			if (byte_ch.valid && byte_ch.ready) begin
				sb.check_word(byte_ch.out_byte, byte_ch.last_byte);
			end
			if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// The receiver stalls in segments of random style, and on request holds off.
	initial begin
		int mode;
		int seg;
		int k;
		byte_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(8, 60);
			for (k = 0; k < seg; k++) begin
				@(negedge clk);
				if (hold_req) begin
					byte_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						0: byte_ch.ready <= 1'b1;
						1: byte_ch.ready <= ($urandom_range(0, 3) != 0);
						2: byte_ch.ready <= ($urandom_range(0, 3) == 0);
						default: byte_ch.ready <= k[0];
					endcase
				end
			end
		end
	end

	function automatic logic [VAL_BITS-1:0] rand_ticks();
		logic [VAL_BITS-1:0] v;
		v[35:32] = 4'($urandom_range(0, 15));
		v[31:0]  = $urandom;
		return v;
	endfunction

	function automatic logic [11:0] rand_chunk();
		case ($urandom_range(0, 3))
			0: return 12'd0;
			1: return CHUNK_ALL;
			default: return 12'($urandom_range(1, 4095));
		endcase
	endfunction

	// Delay amounts spread over chunk patterns, small values and saturation.
	function automatic logic [VAL_BITS-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return VAL_BITS'($urandom_range(1, 15));
			2, 3, 4: return {rand_chunk(), rand_chunk(), rand_chunk()};
			5: return DELAY_MAX - VAL_BITS'($urandom_range(0, 3));
			6: return FULL_CHUNK_TICKS + VAL_BITS'($urandom_range(0, 4095));
			default: return rand_ticks();
		endcase
	endfunction

	// Presents one item from a falling edge and returns at the falling edge after its accept.
	task automatic send_item(op_t op, logic [VAL_BITS-1:0] amount, logic [7:0] num,
			logic [7:0] data);
		item_ch.valid           <= 1'b1;
		item_ch.operation       <= op;
		item_ch.delay_amount    <= amount;
		item_ch.register_number <= num;
		item_ch.register_data   <= data;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// The sender works in bursts; a new burst may start after a gap.
	task automatic offer(op_t op, logic [VAL_BITS-1:0] amount, logic [7:0] num,
			logic [7:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_item(op, amount, num, data);
	endtask

	task automatic offer_delay(logic [VAL_BITS-1:0] amount);
		offer(OP_DELAY, amount, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic offer_write(logic [7:0] num, logic [7:0] data);
		offer(OP_WRITE, rand_ticks(), num, data);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (sb.waiting() != 0) @(negedge clk);
	endtask

	task automatic write_threshold(logic [VAL_BITS-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sb.set_threshold(value);
	endtask

	// Mostly delays followed by a write, with lone delays and unused codes as noise.
	task automatic random_items(int count);
		int sent;
		int kind;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				repeat ($urandom_range(0, 3)) begin
					offer_delay(pick_delay());
					sent++;
				end
				offer_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				sent++;
			end else if (kind == 8) begin
				offer(OP_UNUSED, rand_ticks(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else begin
				offer_delay(pick_delay());
				sent++;
			end
		end
	endtask

	initial begin
		int p;
		logic [VAL_BITS-1:0] level;
		sb                      = new();
		hold_req                = 1'b0;
		burst_left              = 0;
		idle_cycles             = 0;
		arst_n                  = 1'b0;
		cfg_wr_en               = 1'b0;
		cfg_wr_data             = '0;
		item_ch.valid           = 1'b0;
		item_ch.operation       = OP_DELAY;
		item_ch.delay_amount    = '0;
		item_ch.register_number = '0;
		item_ch.register_data   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under the reset threshold of zero.
		offer_write(8'hFF, 8'h00);
		offer(OP_UNUSED, DELAY_MAX, 8'hFF, 8'hFF);
		offer_delay('0);
		offer_write(8'h00, 8'hFF);
		offer_delay(36'd1);
		offer_write(8'hA5, 8'h5A);
		offer_delay(36'hFFF);
		offer_delay(36'h1000);
		offer_write(8'h5A, 8'hA5);
		offer_delay(FULL_CHUNK_TICKS);
		offer_write(8'h3C, 8'hC3);
		offer_delay(DELAY_MAX);
		offer_delay(DELAY_MAX);
		offer_write(8'h0F, 8'hF0);
		offer_delay(36'h001000001);
		offer_write(8'hF0, 8'h0F);

		// Highest threshold: a short total stays pending until saturation.
		write_threshold(DELAY_MAX);
		offer_delay(36'd5);
		offer_write(8'h12, 8'h34);
		offer_delay(DELAY_MAX);
		offer_write(8'h56, 8'h78);

		// A total exactly at the threshold is flushed, one below it is not.
		write_threshold(36'h1000);
		offer_delay(36'hFFF);
		offer_write(8'h9A, 8'hBC);
		offer_delay(36'd1);
		offer_write(8'hDE, 8'hF1);

		// Random phases, each under its own threshold.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: level = '0;
				1: level = 36'd1;
				2: level = VAL_BITS'($urandom_range(1, 32'h2000));
				3: level = rand_ticks();
				4: level = DELAY_MAX;
				5: level = {12'd0, rand_chunk(), 12'd0};
				default: level = '0;
			endcase
			write_threshold(level);
			if (p == 1) begin
				// Hold the receiver off while writes keep coming, so the block backs up.
				hold_req = 1'b1;
				repeat (12) begin
					send_item(OP_WRITE, rand_ticks(), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end
			random_items(PHASE_ITEMS / 2);
			if (p == 3) begin
				wait_drained();
			end
			random_items(PHASE_ITEMS / 2);
		end

		// End of stream; everything after it is dropped.
		wait_drained();
		offer(OP_END, rand_ticks(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		offer_delay(DELAY_MAX);
		offer_write(8'hFF, 8'hFF);
		offer(OP_UNUSED, '0, 8'h00, 8'h00);
		offer(OP_END, '0, 8'h00, 8'h00);
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: register_log_delay_encoder.f
hdl/rlde_pkg.sv
hdl/rlde_ifs.sv
hdl/rlde_fifo.sv
hdl/rlde_front.sv
hdl/rlde_back.sv
hdl/register_log_delay_encoder.sv
tb/sv/rlde_tb_pkg.sv
tb/sv/tb_top.sv
